[design/assert_macros.svh]
// Assertion macros shared by the RTL of the text console writer.
// Each macro expands to one labeled concurrent assertion that reports through $error.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// The antecedent implies the consequent at the same clock edge.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The antecedent implies the consequent at the following clock edge.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/tcw_pkg.sv]
// Package of the text console writer: command codes, character codes and field widths.
// It depends on nothing; text_console_writer imports it.
`default_nettype none

package tcw_pkg;

    localparam int CMD_W        = 2;
    localparam int CHAR_W       = 8;
    localparam int ATTR_W       = 8;
    localparam int READ_IDX_W   = 11;
    localparam int ROW_OUT_W    = 5;
    localparam int COL_OUT_W    = 7;
    localparam int IN_DATA_W    = 24;
    localparam int OUT_DATA_W   = 32;

    localparam logic [CMD_W-1:0] CMD_PUT   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

    localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'h0a;
    localparam logic [CHAR_W-1:0] BLANK_CODE   = 8'h20;
    localparam logic [ATTR_W-1:0] ATTR_RESET   = 8'h0f;

endpackage

`default_nettype wire

[design/text_console_writer.sv]
// Text console writer: cursor sequencer and screen cell store in one module.
// It depends on tcw_pkg and on assert_macros.svh.
//
// Usage:
// Commands arrive as beats on the s_ channel (command in s_tuser, character and read
// index in s_tdata). Every command gives exactly one result beat on the m_ channel with
// the cursor after the command and, for a read, the stored character and attribute.
// The attribute register is written over the cfg_ channel, which is always ready; the user
// must write it only while no command is in progress, as the block does not enforce this.
// The block works on one command at a time and drops s_tready from acceptance until its
// result is loaded into the output register. A put passes through the put and deliver
// states, a read of a cell on the screen through the read and deliver states, and a
// read outside the screen or an unknown command goes straight to deliver. A put that
// finds a scroll pending first moves the screen up through the single memory port pair,
// one cell per cycle. A clear writes one cell per cycle. The cell store has no reset,
// so a cell holds an unknown value until it is first written.
// When the receiver stalls, the result waits in the output register and the block holds
// the next finished result until that register frees up. Reset homes the cursor, sets
// the attribute to 0x0f and empties the output register.
`default_nettype none
`include "assert_macros.svh"

module text_console_writer
    import tcw_pkg::*;
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // Fields from bit 0: char_code[7:0], read_index[18:8], zero fill.
    input  wire logic [IN_DATA_W-1:0]  s_tdata,
    // Fields from bit 0: command[1:0].
    input  wire logic [CMD_W-1:0]      s_tuser,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // Fields from bit 0: cursor_row[4:0], cursor_column[11:5], cell_char[19:12],
    // cell_attribute[27:20], zero fill.
    output logic [OUT_DATA_W-1:0]      m_tdata,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [ATTR_W-1:0]     cfg_data
);

    localparam int CELLS  = ROWS * COLUMNS;
    localparam int ROW_W  = $clog2(ROWS + 1);
    localparam int COL_W  = $clog2(COLUMNS + 1);
    localparam int LIN_W  = $clog2(CELLS + 1);
    localparam int ADDR_W = $clog2(CELLS);
    localparam int CMP_W  = ($clog2(CELLS + 1) > READ_IDX_W) ? $clog2(CELLS + 1) : READ_IDX_W;
    localparam int CELL_W = CHAR_W + ATTR_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCROLL_MOVE,
        ST_SCROLL_BLANK,
        ST_PUT,
        ST_CLEAR,
        ST_READ,
        ST_DELIVER
    } state_t;

    state_t                  state_reg;
    logic [ROW_W-1:0]        row_reg;
    logic [COL_W-1:0]        col_reg;
    logic [LIN_W-1:0]        cur_addr_reg;
    logic [LIN_W-1:0]        sweep_reg;
    logic [ADDR_W-1:0]       move_addr_reg;
    logic                    move_pend_reg;
    logic [ATTR_W-1:0]       attr_reg;
    logic [CHAR_W-1:0]       code_reg;
    logic [CHAR_W-1:0]       res_char_reg;
    logic [ATTR_W-1:0]       res_attr_reg;
    logic                    m_valid_reg;
    logic [OUT_DATA_W-1:0]   m_data_reg;

    logic [CELL_W-1:0]       mem [CELLS];
    logic [CELL_W-1:0]       rd_data_reg;

    logic                    accept;
    logic [CMD_W-1:0]        in_cmd;
    logic [CHAR_W-1:0]       in_char;
    logic [READ_IDX_W-1:0]   in_idx;
    logic                    idx_valid;
    logic                    rd_en;
    logic [ADDR_W-1:0]       rd_addr;
    logic                    wr_en;
    logic [ADDR_W-1:0]       wr_addr;
    logic [CELL_W-1:0]       wr_data;
    logic [COL_W-1:0]        col_inc;
    logic                    sweep_at_end;
    logic                    sweep_at_last;
    logic                    out_free;

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;

    assign accept    = s_tvalid && s_tready;
    assign in_cmd    = s_tuser;
    assign in_char   = s_tdata[CHAR_W-1:0];
    assign in_idx    = s_tdata[CHAR_W+READ_IDX_W-1:CHAR_W];
    assign idx_valid = (CMP_W'(in_idx) < CMP_W'(CELLS));

    assign col_inc       = col_reg + COL_W'(1);
    assign sweep_at_end  = (sweep_reg == LIN_W'(CELLS));
    assign sweep_at_last = (sweep_reg == LIN_W'(CELLS - 1));
    assign out_free      = !m_valid_reg || m_tready;

    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = ADDR_W'(in_idx);
        wr_en   = 1'b0;
        wr_addr = sweep_reg[ADDR_W-1:0];
        wr_data = {attr_reg, BLANK_CODE};
        case (state_reg)
            ST_IDLE:
            begin
                rd_en = accept && (in_cmd == CMD_READ) && idx_valid;
            end
            ST_SCROLL_MOVE:
            begin
                rd_en   = !sweep_at_end;
                rd_addr = sweep_reg[ADDR_W-1:0];
                wr_en   = move_pend_reg;
                wr_addr = move_addr_reg;
                wr_data = rd_data_reg;
            end
            ST_SCROLL_BLANK, ST_CLEAR:
            begin
                wr_en = 1'b1;
            end
            ST_PUT:
            begin
                wr_en   = (code_reg != NEWLINE_CODE);
                wr_addr = cur_addr_reg[ADDR_W-1:0];
                wr_data = {attr_reg, code_reg};
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            row_reg       <= '0;
            col_reg       <= '0;
            cur_addr_reg  <= '0;
            sweep_reg     <= '0;
            move_addr_reg <= '0;
            attr_reg      <= ATTR_RESET;
            code_reg      <= '0;
            res_char_reg  <= '0;
            res_attr_reg  <= '0;
            m_valid_reg   <= 1'b0;
            m_data_reg    <= '0;
            move_pend_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                attr_reg <= cfg_data;
            end
            if (m_valid_reg && m_tready && (state_reg != ST_DELIVER))
            begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        code_reg     <= in_char;
                        res_char_reg <= '0;
                        res_attr_reg <= '0;
                        sweep_reg    <= '0;
                        case (in_cmd)
                            CMD_PUT:
                            begin
                                if (row_reg >= ROW_W'(ROWS))
                                begin
                                    sweep_reg     <= LIN_W'(COLUMNS);
                                    move_pend_reg <= 1'b0;
                                    state_reg     <= ST_SCROLL_MOVE;
                                end
                                else
                                begin
                                    state_reg <= ST_PUT;
                                end
                            end
                            CMD_CLEAR:
                            begin
                                state_reg <= ST_CLEAR;
                            end
                            CMD_READ:
                            begin
                                state_reg <= idx_valid ? ST_READ : ST_DELIVER;
                            end
                            default:
                            begin
                                state_reg <= ST_DELIVER;
                            end
                        endcase
                    end
                end
                ST_SCROLL_MOVE:
                begin
                    if (sweep_at_end)
                    begin
                        move_pend_reg <= 1'b0;
                        sweep_reg     <= LIN_W'(CELLS - COLUMNS);
                        state_reg     <= ST_SCROLL_BLANK;
                    end
                    else
                    begin
                        move_pend_reg <= 1'b1;
                        move_addr_reg <= ADDR_W'(sweep_reg - LIN_W'(COLUMNS));
                        sweep_reg     <= sweep_reg + LIN_W'(1);
                    end
                end
                ST_SCROLL_BLANK:
                begin
                    sweep_reg <= sweep_reg + LIN_W'(1);
                    if (sweep_at_last)
                    begin
                        row_reg      <= row_reg - ROW_W'(1);
                        col_reg      <= '0;
                        cur_addr_reg <= LIN_W'(CELLS - COLUMNS);
                        state_reg    <= ST_PUT;
                    end
                end
                ST_PUT:
                begin
                    if (code_reg == NEWLINE_CODE)
                    begin
                        row_reg      <= row_reg + ROW_W'(1);
                        col_reg      <= '0;
                        cur_addr_reg <= cur_addr_reg + LIN_W'(COLUMNS) - LIN_W'(col_reg);
                    end
                    else
                    begin
                        cur_addr_reg <= cur_addr_reg + LIN_W'(1);
                        if (col_inc == COL_W'(COLUMNS))
                        begin
                            row_reg <= row_reg + ROW_W'(1);
                            col_reg <= '0;
                        end
                        else
                        begin
                            col_reg <= col_inc;
                        end
                    end
                    state_reg <= ST_DELIVER;
                end
                ST_CLEAR:
                begin
                    sweep_reg <= sweep_reg + LIN_W'(1);
                    if (sweep_at_last)
                    begin
                        row_reg      <= '0;
                        col_reg      <= '0;
                        cur_addr_reg <= '0;
                        state_reg    <= ST_DELIVER;
                    end
                end
                ST_READ:
                begin
                    res_char_reg <= rd_data_reg[CHAR_W-1:0];
                    res_attr_reg <= rd_data_reg[CELL_W-1:CHAR_W];
                    state_reg    <= ST_DELIVER;
                end
                ST_DELIVER:
                begin
                    if (out_free)
                    begin
                        m_valid_reg <= 1'b1;
                        m_data_reg  <= {4'b0000, res_attr_reg, res_char_reg,
                                        COL_OUT_W'(col_reg), ROW_OUT_W'(row_reg)};
                        state_reg   <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    `ASSERT_ALWAYS(a_row_range, clk, rst_n, row_reg <= ROW_W'(ROWS),
        "cursor row beyond row count")
    `ASSERT_IMPLY(a_col_range, clk, rst_n, state_reg == ST_IDLE,
        col_reg < COL_W'(COLUMNS), "cursor column beyond row end")
    `ASSERT_IMPLY(a_addr_track, clk, rst_n, state_reg == ST_IDLE,
        32'(cur_addr_reg) == 32'(row_reg) * COLUMNS + 32'(col_reg),
        "linear cursor address out of step with row and column")
    `ASSERT_NEXT(a_busy_after_accept, clk, rst_n, s_tvalid && s_tready, !s_tready,
        "command accepted while another is in progress")

endmodule

`default_nettype wire

[sim/text_console_checker.sv]
`timescale 1ns / 100ps
// Checker for the text console writer: watches the command, result and attribute channels,
// keeps its own screen, cursor and attribute, and compares every result beat in order.
// It depends on tcw_pkg for widths and command codes.

module text_console_checker
    import tcw_pkg::*;
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  logic [CMD_W-1:0]      s_tuser,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [OUT_DATA_W-1:0] m_tdata,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [ATTR_W-1:0]     cfg_data,
    output int                    fail_count,
    output int                    outstanding
);

    localparam int CELL_COUNT = ROWS * COLUMNS;

    typedef struct packed {
        logic [ROW_OUT_W-1:0] row;
        logic [COL_OUT_W-1:0] column;
        logic [CHAR_W-1:0]    cell_char;
        logic [ATTR_W-1:0]    cell_attr;
    } console_result_t;

    console_result_t        expected_results[$];
    logic [15:0]            screen_cells[0:CELL_COUNT-1];
    int unsigned            cursor_row;
    int unsigned            cursor_column;
    logic [ATTR_W-1:0]      text_attribute;
    console_result_t        expected;

    function automatic console_result_t predict_console_step(input logic [CMD_W-1:0] command,
                                                             input logic [CHAR_W-1:0] code,
                                                             input logic [READ_IDX_W-1:0] index);
        console_result_t result;
        int k;
        result = '0;
        case (command)
            CMD_PUT:
            begin
                if (cursor_row >= ROWS)
                begin
                    for (k = 0; k < CELL_COUNT - COLUMNS; k++)
                        screen_cells[k] = screen_cells[k + COLUMNS];
                    for (k = CELL_COUNT - COLUMNS; k < CELL_COUNT; k++)
                        screen_cells[k] = {text_attribute, BLANK_CODE};
                    cursor_column = 0;
                    cursor_row--;
                end
                if (code == NEWLINE_CODE)
                begin
                    cursor_row++;
                    cursor_column = 0;
                end
                else
                begin
                    screen_cells[cursor_row * COLUMNS + cursor_column] = {text_attribute, code};
                    cursor_column++;
                    if (cursor_column >= COLUMNS)
                    begin
                        cursor_row++;
                        cursor_column = 0;
                    end
                end
            end
            CMD_CLEAR:
            begin
                for (k = 0; k < CELL_COUNT; k++)
                    screen_cells[k] = {text_attribute, BLANK_CODE};
                cursor_row = 0;
                cursor_column = 0;
            end
            CMD_READ:
            begin
                if (int'(index) < CELL_COUNT)
                begin
                    result.cell_char = screen_cells[index][7:0];
                    result.cell_attr = screen_cells[index][15:8];
                end
            end
            default:
            begin
            end
        endcase
        result.row = cursor_row[ROW_OUT_W-1:0];
        result.column = cursor_column[COL_OUT_W-1:0];
        return result;
    endfunction

    task automatic check_field(input string field_name, input logic [31:0] expected_value,
                               input logic [31:0] actual_value);
        if (expected_value !== actual_value)
        begin
            $error("%s mismatch: expected %0d, got %0d", field_name, expected_value,
                   actual_value);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_results.delete();
            cursor_row = 0;
            cursor_column = 0;
            text_attribute = ATTR_RESET;
            fail_count = 0;
            outstanding = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result beat %h with no command waiting", m_tdata);
                    fail_count++;
                end
                else
                begin
                    expected = expected_results.pop_front();
                    check_field("cursor_row", expected.row, m_tdata[4:0]);
                    check_field("cursor_column", expected.column, m_tdata[11:5]);
                    check_field("cell_char", expected.cell_char, m_tdata[19:12]);
                    check_field("cell_attribute", expected.cell_attr, m_tdata[27:20]);
                end
            end
            if (cfg_valid && cfg_ready)
                text_attribute = cfg_data;
            if (s_tvalid && s_tready)
                expected_results.push_back(predict_console_step(s_tuser, s_tdata[7:0],
                                                                s_tdata[18:8]));
            outstanding = expected_results.size();
        end
    end

endmodule

[sim/tb.sv]
`timescale 1ns / 100ps
// Testbench top for the text console writer: clock, reset, command and attribute stimulus
// with random idling on both sides, and the verdict. Depends on tcw_pkg, text_console_writer
// and text_console_checker.

module tb;
    import tcw_pkg::*;

    localparam int COLUMNS = 80;
    localparam int ROWS    = 25;
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic [CMD_W-1:0]      s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [ATTR_W-1:0]     cfg_data;
    logic                  quiet_phase;
    int                    fail_count;
    int                    outstanding;

    text_console_writer #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    text_console_checker #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic int idle_cycles();
        int roll;
        roll = $urandom_range(0, 99);
        if (quiet_phase)
            return 0;
        if (roll < 55)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(negedge clk);
        while (outstanding != 0)
            @(negedge clk);
        @(posedge clk);
    endtask

    task automatic send_command(input logic [CMD_W-1:0] command, input logic [CHAR_W-1:0] code,
                                input logic [READ_IDX_W-1:0] index);
        int gap;
        if (!quiet_phase && $urandom_range(0, 39) == 0)
            drain_results();
        gap = idle_cycles();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= command;
        s_tdata <= {5'd0, index, code};
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    task automatic write_text_attribute(input logic [ATTR_W-1:0] value);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // Most of the traffic is lines of text ending in a newline, short enough that the
    // cursor soon reaches the bottom and every further line scrolls the screen.
    task automatic run_random_items(input int count);
        int sent;
        int pick;
        int line_length;
        int k;
        sent = 0;
        while (sent < count)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 60)
            begin
                line_length = ($urandom_range(0, 9) == 0) ? $urandom_range(70, 170)
                                                           : $urandom_range(0, 8);
                for (k = 0; k < line_length; k++)
                    send_command(CMD_PUT, 8'($urandom), 11'($urandom));
                send_command(CMD_PUT, NEWLINE_CODE, 11'($urandom));
                sent += line_length + 1;
            end
            else
            begin
                if (pick < 88)
                    send_command(CMD_READ, 8'($urandom), 11'($urandom));
                else if (pick < 94)
                    send_command(CMD_PUT, 8'($urandom), 11'($urandom));
                else if (pick < 97)
                    send_command(CMD_UNUSED, 8'($urandom), 11'($urandom));
                else
                    send_command(CMD_CLEAR, 8'($urandom), 11'($urandom));
                sent++;
            end
        end
    endtask

    initial
    begin
        m_tready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            int stall;
            stall = idle_cycles();
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
    end

    initial
    begin
        int k;
        int phase;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        s_tuser <= CMD_PUT;
        cfg_valid <= 1'b0;
        cfg_data <= '0;
        quiet_phase = 1'b0;
        rst_n <= 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Before the first clear only cells that were just written are read back.
        send_command(CMD_PUT, 8'h41, 11'h7ff);
        send_command(CMD_READ, 8'hff, 11'd0);
        send_command(CMD_PUT, 8'h00, 11'd0);
        send_command(CMD_PUT, 8'hff, 11'd0);
        send_command(CMD_READ, 8'h00, 11'd1);
        send_command(CMD_READ, 8'h00, 11'd2);
        send_command(CMD_UNUSED, 8'hff, 11'h7ff);
        send_command(CMD_CLEAR, 8'h00, 11'd0);
        send_command(CMD_READ, 8'h00, 11'd0);
        send_command(CMD_READ, 8'h00, 11'(ROWS * COLUMNS - 1));
        send_command(CMD_READ, 8'h00, 11'(ROWS * COLUMNS));
        send_command(CMD_READ, 8'h00, 11'h7ff);
        // Walk the cursor below the last row, then a newline and a character each
        // arrive with a scroll pending.
        for (k = 0; k < ROWS; k++)
            send_command(CMD_PUT, NEWLINE_CODE, 11'($urandom));
        send_command(CMD_PUT, NEWLINE_CODE, 11'd0);
        send_command(CMD_PUT, 8'h5a, 11'd0);
        send_command(CMD_READ, 8'h00, 11'((ROWS - 1) * COLUMNS));

        for (phase = 0; phase < 5; phase++)
        begin
            case (phase)
                0: write_text_attribute(8'h00);
                1: write_text_attribute(8'hff);
                3: write_text_attribute(8'h80);
                default: write_text_attribute(8'($urandom));
            endcase
            quiet_phase = (phase == 2);
            run_random_items(130);
        end
        quiet_phase = 1'b0;

        drain_results();
        repeat (20) @(posedge clk);
        if (fail_count == 0 && outstanding == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        #(200_000_000);
        $display("Simulation FAILED");
        $finish;
    end

endmodule
